// ===== rtl/core/priority_ceiling_lock_tracker_assert.svh =====
// Assertion macros for the priority ceiling lock tracker.
`ifndef PRIORITY_CEILING_LOCK_TRACKER_ASSERT_SVH
`define PRIORITY_CEILING_LOCK_TRACKER_ASSERT_SVH

`ifndef SYNTH
// Check that a property holds at every rising edge outside reset.
`define PCLT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define PCLT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PCLT_ASSERT(name, prop, msg)
`define PCLT_NEVER(name, cond, msg)
`endif

`endif

// ===== rtl/core/pclt_pkg.sv =====
// Shared types, codes and helpers for the priority ceiling lock tracker.
package pclt_pkg;

  localparam int NUM_TASKS_DEF      = 8;
  localparam int NUM_SEMAPHORES_DEF = 4;

  localparam int PRIO_W       = 8;
  localparam int MODE_W       = 2;
  localparam int TASK_FIELD_W = 3;
  localparam int SEM_FIELD_W  = 2;
  localparam int NUM_CEILINGS = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 8;

  // Protocol modes.
  localparam logic [MODE_W-1:0] MODE_NONE           = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NONPREEMPT     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HIGHEST_LOCKER = 2'd2;

  // Lock operations.
  localparam logic OP_ENTER = 1'b0;
  localparam logic OP_LEAVE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_PRIORITY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING_SEM0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING_SEM1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING_SEM2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING_SEM3  = 3'd5;

  typedef struct packed {
    logic                    op;
    logic [SEM_FIELD_W-1:0]  semaphore_index;
    logic [TASK_FIELD_W-1:0] task_index;
  } pclt_in_t;

  typedef struct packed {
    logic              priority_change;
    logic [PRIO_W-1:0] new_priority;
    logic              nesting_fault;
  } pclt_out_t;

  // State update requested by the decision logic.
  typedef struct packed {
    logic              cnt_inc;
    logic              cnt_dec;
    logic              stk_push;
    logic [PRIO_W-1:0] push_level;
  } pclt_ctl_t;

  // Level below a task's first push: top priority plus task number, saturated.
  function automatic logic [PRIO_W-1:0] base_level(input logic [PRIO_W-1:0] top,
                                                   input logic [TASK_FIELD_W-1:0] tsk);
    logic [PRIO_W:0] sum;
    sum = {1'b0, top} + (PRIO_W + 1)'(tsk);
    return sum[PRIO_W] ? {PRIO_W{1'b1}} : sum[PRIO_W-1:0];
  endfunction

endpackage

// ===== rtl/core/pclt_step.sv =====
// Decision logic for one lock transaction: result fields and state update.
module pclt_step import pclt_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF,
  parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
  localparam int CNT_W = $clog2(NUM_SEMAPHORES + 1)
) (
  input  logic [MODE_W-1:0] mode,
  input  logic [PRIO_W-1:0] highest_prio,
  input  logic [PRIO_W-1:0] ceiling,
  input  pclt_in_t          item,
  input  logic [CNT_W-1:0]  nest_level,
  input  logic [PRIO_W-1:0] tos_level,
  input  logic [PRIO_W-1:0] below_level,
  output pclt_out_t         result,
  output pclt_ctl_t         ctl
);

  logic              active;
  logic [PRIO_W-1:0] base;
  logic [PRIO_W-1:0] cur;
  logic [PRIO_W-1:0] lower;

  assign active = (mode == MODE_NONPREEMPT || mode == MODE_HIGHEST_LOCKER) &&
                  item.task_index != '0 &&
                  int'(item.task_index) < NUM_TASKS &&
                  int'(item.semaphore_index) < NUM_SEMAPHORES;

  assign base  = base_level(highest_prio, item.task_index);
  assign cur   = (nest_level == '0) ? base : tos_level;
  assign lower = (nest_level == CNT_W'(1)) ? base : below_level;

  always_comb begin
    result = '0;
    ctl    = '0;
    if (active) begin
      if (item.op == OP_ENTER) begin
        if (int'(nest_level) >= NUM_SEMAPHORES) begin
          result.nesting_fault = 1'b1;
        end else if (mode == MODE_NONPREEMPT) begin
          ctl.cnt_inc = 1'b1;
          if (nest_level == '0) begin
            result.priority_change = 1'b1;
            result.new_priority    = highest_prio;
          end
        end else begin
          ctl.cnt_inc    = 1'b1;
          ctl.stk_push   = 1'b1;
          ctl.push_level = cur;
          if (ceiling < cur) begin
            result.priority_change = 1'b1;
            result.new_priority    = ceiling;
            ctl.push_level         = ceiling;
          end
        end
      end else begin
        if (nest_level == '0) begin
          result.nesting_fault = 1'b1;
        end else if (mode == MODE_NONPREEMPT) begin
          ctl.cnt_dec = 1'b1;
          if (nest_level == CNT_W'(1)) begin
            result.priority_change = 1'b1;
            result.new_priority    = base;
          end
        end else begin
          ctl.cnt_dec = 1'b1;
          if (lower > cur) begin
            result.priority_change = 1'b1;
            result.new_priority    = lower;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/pclt_store.sv =====
// Per-task nesting counts, top-of-stack levels and the priority stack.
module pclt_store import pclt_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF,
  parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
  localparam int CNT_W = $clog2(NUM_SEMAPHORES + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [TASK_FIELD_W-1:0] task_index,
  input  logic                    update,
  input  pclt_ctl_t               ctl,
  output logic [CNT_W-1:0]        nest_level,
  output logic [PRIO_W-1:0]       tos_level,
  output logic [PRIO_W-1:0]       below_level
);

  // Only tasks the task field can name need storage.
  localparam int EFF_TASKS = (NUM_TASKS < (1 << TASK_FIELD_W)) ? NUM_TASKS
                                                               : (1 << TASK_FIELD_W);
  localparam int TASK_W = $clog2(EFF_TASKS);
  localparam int DEPTH  = EFF_TASKS * NUM_SEMAPHORES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [CNT_W-1:0]  nest_count [EFF_TASKS];
  logic [PRIO_W-1:0] tos        [EFF_TASKS];
  logic [PRIO_W-1:0] stack      [DEPTH];

  logic [TASK_W-1:0] tsel;
  logic [ADDR_W-1:0] push_addr;
  logic [ADDR_W-1:0] below_addr;

  assign tsel        = task_index[TASK_W-1:0];
  assign nest_level  = nest_count[tsel];
  assign tos_level   = tos[tsel];
  assign push_addr   = ADDR_W'(int'(tsel) * NUM_SEMAPHORES + int'(nest_level));
  // Level just under the top of stack; only meaningful at depth two or more.
  assign below_addr  = ADDR_W'(int'(tsel) * NUM_SEMAPHORES + int'(nest_level) - 2);
  assign below_level = stack[below_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < EFF_TASKS; i++) begin
        nest_count[i] <= '0;
      end
    end else if (update && ctl.cnt_inc) begin
      nest_count[tsel] <= nest_level + CNT_W'(1);
    end else if (update && ctl.cnt_dec) begin
      nest_count[tsel] <= nest_level - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (update && ctl.stk_push) begin
      tos[tsel]        <= ctl.push_level;
      stack[push_addr] <= ctl.push_level;
    end else if (update && ctl.cnt_dec) begin
      tos[tsel] <= below_level;
    end
  end

endmodule

// ===== rtl/core/priority_ceiling_lock_tracker.sv =====
// Top level of the priority ceiling lock tracker.
//
// Tracks lock entry and exit transactions of up to NUM_TASKS tasks on
// NUM_SEMAPHORES semaphores and reports, for each one, whether the task's
// priority must be set now and to what value (lower value = higher priority).
// Mode 1 raises a task to the highest priority register value on its first
// entry and restores that value plus the task number on its last exit; mode 2
// (highest locker) keeps a stack of effective levels per task and raises to
// the semaphore ceiling on entry, restoring the uncovered level on exit.
// Task 0, out-of-range indexes and modes 0 and 3 give an all-zero result;
// nesting overflow or underflow sets nesting_fault and changes nothing. Every
// lock transaction yields exactly one result transaction. Throughput is one
// transaction per clock while prio_ready does not stall the output; the
// per-task count and stack registers are read and written back between the
// input register and the result register. No clearing pass follows reset.
// Configuration writes take effect at once and are expected only while idle.
module priority_ceiling_lock_tracker import pclt_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF,
  parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Lock transactions in.
  input  logic                  lock_valid,
  output logic                  lock_ready,
  input  pclt_in_t              lock_event,
  // Priority results out.
  output logic                  prio_valid,
  input  logic                  prio_ready,
  output pclt_out_t             prio_update,
  // Register writes.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(NUM_SEMAPHORES + 1);

  // Configuration registers.
  logic [MODE_W-1:0] protocol_mode;
  logic [PRIO_W-1:0] highest_prio;
  logic [PRIO_W-1:0] ceiling [NUM_CEILINGS];

  // Input register.
  pclt_in_t held_item;
  logic     held_valid;

  logic              advance;
  logic [CNT_W-1:0]  nest_level;
  logic [PRIO_W-1:0] tos_level;
  logic [PRIO_W-1:0] below_level;
  pclt_out_t         result;
  pclt_ctl_t         ctl;

  // Move the held transaction into the result register when that register
  // is empty or being drained this cycle; the state update happens at the
  // same edge, so the next transaction always sees it.
  assign advance    = held_valid && (!prio_valid || prio_ready);
  assign lock_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_mode <= MODE_NONE;
      highest_prio  <= '0;
      for (int i = 0; i < NUM_CEILINGS; i++) begin
        ceiling[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROTOCOL_MODE: protocol_mode <= cfg_wdata[MODE_W-1:0];
        REG_TOP_PRIORITY:  highest_prio  <= cfg_wdata[PRIO_W-1:0];
        REG_CEILING_SEM0:  ceiling[0]    <= cfg_wdata[PRIO_W-1:0];
        REG_CEILING_SEM1:  ceiling[1]    <= cfg_wdata[PRIO_W-1:0];
        REG_CEILING_SEM2:  ceiling[2]    <= cfg_wdata[PRIO_W-1:0];
        REG_CEILING_SEM3:  ceiling[3]    <= cfg_wdata[PRIO_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Handshake control: hold a transaction until it advances, hold a result
  // until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      prio_valid <= 1'b0;
    end else begin
      if (lock_ready) begin
        held_valid <= lock_valid;
      end
      if (advance) begin
        prio_valid <= 1'b1;
      end else if (prio_ready) begin
        prio_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lock_valid && lock_ready) begin
      held_item <= lock_event;
    end
    if (advance) begin
      prio_update <= result;
    end
  end

  pclt_store #(
    .NUM_TASKS      (NUM_TASKS),
    .NUM_SEMAPHORES (NUM_SEMAPHORES)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .task_index  (held_item.task_index),
    .update      (advance),
    .ctl         (ctl),
    .nest_level  (nest_level),
    .tos_level   (tos_level),
    .below_level (below_level)
  );

  pclt_step #(
    .NUM_TASKS      (NUM_TASKS),
    .NUM_SEMAPHORES (NUM_SEMAPHORES)
  ) u_step (
    .mode         (protocol_mode),
    .highest_prio (highest_prio),
    .ceiling      (ceiling[held_item.semaphore_index]),
    .item         (held_item),
    .nest_level   (nest_level),
    .tos_level    (tos_level),
    .below_level  (below_level),
    .result       (result),
    .ctl          (ctl)
  );

`include "priority_ceiling_lock_tracker_assert.svh"

  // An entry that raises the count must start below the nesting limit.
  `PCLT_ASSERT(a_no_overflow, advance && ctl.cnt_inc |-> int'(nest_level) < NUM_SEMAPHORES, "nesting count overflow")
  // An exit that lowers the count must start above zero.
  `PCLT_ASSERT(a_no_underflow, advance && ctl.cnt_dec |-> nest_level != '0, "nesting count underflow")
  // An empty result register never stalls the input side.
  `PCLT_ASSERT(a_ready_when_empty, !prio_valid |-> lock_ready, "input stalled with empty output")
  // A fault never comes with a priority change or a state update.
  `PCLT_NEVER(a_fault_quiet, advance && result.nesting_fault && (result.priority_change || ctl.cnt_inc || ctl.cnt_dec), "fault with side effects")

endmodule
